// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/ppt_pkg.sv
package ppt_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_WIDTH  = 16;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CSR_W        = 5;
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int VTX_W        = 2 * COORD_WIDTH;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_W-1:0] COUNT_RESET = CSR_W'(4);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [CSR_W-1:0]              count_type;
   typedef logic [VTX_W-1:0]              vtx_type;

endpackage

// File: rtl/core/point_in_polygon_test_unit.sv
// a query runs ST_PREV, then ST_LOAD, ST_MUL_L, ST_MUL_R and ST_CMP for each of the n vertices in use
// a query with no vertices gives its result in the cycle after accept
// one query at a time; each edge uses the shared multiplier in ST_MUL_L and ST_MUL_R
// a load writes the vertex memory on accept and gives no result
// synchronous active-high reset clears control state and sets count_ff to 4
module point_in_polygon_test_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [ppt_pkg::IDX_W-1:0]    req_vertex_index,
   input  logic signed [ppt_pkg::COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [ppt_pkg::COORD_WIDTH-1:0] req_vertex_z,
   input  logic signed [ppt_pkg::COORD_WIDTH-1:0] req_point_x,
   input  logic signed [ppt_pkg::COORD_WIDTH-1:0] req_point_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_inside_res,
   input  logic                         csr_wr_en,
   input  logic [ppt_pkg::CSR_W-1:0]    csr_wr_data
);

   import ppt_pkg::*;

   `include "assert_macros.svh"

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREV  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_MUL_L = 3'd3;
   localparam logic [2:0] ST_MUL_R = 3'd4;
   localparam logic [2:0] ST_CMP   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam count_type MAX_CNT = CSR_W'(MAX_VERTICES);

   logic [2:0] state_ff, state_in;
   count_type  count_ff, count_in;
   idx_type    idx_ff, idx_in;
   idx_type    last_ff, last_in;
   coord_type  px_ff, px_in, pz_ff, pz_in;
   coord_type  xp_ff, xp_in, zp_ff, zp_in;
   diff_type   da_ff, da_in, dz_ff, dz_in, db_ff, db_in, dc_ff, dc_in;
   logic       strad_ff, strad_in;
   prod_type   prodl_ff, prodl_in, prodr_ff, prodr_in;
   logic       parity_ff, parity_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       req_fire;
   count_type  n_sat;
   count_type  n_last;
   logic       wr_en;
   logic       rd_en;
   idx_type    rd_addr;
   vtx_type    rd_data;
   coord_type  xc, zc;
   diff_type   op_a, op_b;
   prod_type   mul_out;
   logic       crosses;
   logic       last_edge;
   logic       empty_query;

   ppt_ram #(
      .WIDTH (VTX_W),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_vertex_index),
      .wr_data ({req_vertex_x, req_vertex_z}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = parity_ff;

   assign n_sat  = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign n_last = n_sat - CSR_W'(1);
   assign xc     = rd_data[VTX_W-1:COORD_WIDTH];
   assign zc     = rd_data[COORD_WIDTH-1:0];

   // shared multiplier
   assign op_a    = (state_ff == ST_MUL_L) ? da_ff : db_ff;
   assign op_b    = (state_ff == ST_MUL_L) ? dz_ff : dc_ff;
   assign mul_out = op_a * op_b;

   assign crosses = strad_ff &&
      ((dz_ff > 0) ? (prodl_ff < prodr_ff) : (prodr_ff < prodl_ff));

   assign last_edge   = (state_ff == ST_CMP) && (idx_ff == last_ff);
   assign empty_query = req_fire && (req_type == REQ_QUERY) && (n_sat == '0) && !csr_wr_en;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      px_in        = px_ff;
      pz_in        = pz_ff;
      xp_in        = xp_ff;
      zp_in        = zp_ff;
      da_in        = da_ff;
      dz_in        = dz_ff;
      db_in        = db_ff;
      dc_in        = dc_ff;
      strad_in     = strad_ff;
      prodl_in     = prodl_ff;
      prodr_in     = prodr_ff;
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_LOAD) begin
                  wr_en = 1'b1;
               end else begin
                  px_in     = req_point_x;
                  pz_in     = req_point_z;
                  parity_in = 1'b0;
                  last_in   = n_last[IDX_W-1:0];
                  if (n_sat == '0) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = n_last[IDX_W-1:0];
                     state_in = ST_PREV;
                  end
               end
            end
         end
         ST_PREV: begin
            xp_in    = xc;
            zp_in    = zc;
            idx_in   = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            da_in    = diff_type'(px_ff) - diff_type'(xc);
            dz_in    = diff_type'(zp_ff) - diff_type'(zc);
            db_in    = diff_type'(xp_ff) - diff_type'(xc);
            dc_in    = diff_type'(pz_ff) - diff_type'(zc);
            strad_in = (zc > pz_ff) != (zp_ff > pz_ff);
            xp_in    = xc;
            zp_in    = zc;
            state_in = ST_MUL_L;
         end
         ST_MUL_L: begin
            prodl_in = mul_out;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            prodr_in = mul_out;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            parity_in = parity_ff ^ crosses;
            if (idx_ff == last_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               rd_en    = 1'b1;
               rd_addr  = idx_ff + IDX_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         idx_ff       <= '0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      px_ff    <= px_in;
      pz_ff    <= pz_in;
      xp_ff    <= xp_in;
      zp_ff    <= zp_in;
      da_ff    <= da_in;
      dz_ff    <= dz_in;
      db_ff    <= db_in;
      dc_ff    <= dc_in;
      strad_ff <= strad_in;
      prodl_ff <= prodl_in;
      prodr_ff <= prodr_in;
   end

   `ASSERT_SAME(a_no_accept_while_result, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_mul_order, clock, reset, state_ff == ST_MUL_L, state_ff == ST_MUL_R)
   `ASSERT_NEXT(a_last_edge_done, clock, reset, last_edge, rsp_valid && (state_ff == ST_DONE))
   `ASSERT_NEXT(a_empty_query, clock, reset, empty_query, rsp_valid && !rsp_inside_res)

endmodule

// File: rtl/core/ppt_ram.sv
module ppt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
